// File: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
`default_nettype none

package spq_pkg;

   localparam int DATA_WIDTH     = 32;
   localparam int PRIO_IN_WIDTH  = 8;
   localparam int OCC_WIDTH      = 5;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic enq;
      logic deq;
   } cell_cmd_type;

endpackage

`default_nettype wire

// File: hdl/spq_req_if.sv
// Request channel carrying one queue operation word.
`default_nettype none

interface spq_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   opcode;
   logic signed [spq_pkg::DATA_WIDTH-1:0]  item_data;
   logic [spq_pkg::PRIO_IN_WIDTH-1:0]      item_priority;

   modport source (output valid, output opcode, output item_data, output item_priority,
                   input ready);
   modport sink (input valid, input opcode, input item_data, input item_priority,
                 output ready);
endinterface

`default_nettype wire

// File: hdl/spq_rsp_if.sv
// Response channel carrying one result word per operation.
`default_nettype none

interface spq_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [spq_pkg::DATA_WIDTH-1:0]  out_data;
   spq_pkg::status_type                    status;
   logic [spq_pkg::OCC_WIDTH-1:0]          occupancy;

   modport source (output valid, output out_data, output status, output occupancy,
                   input ready);
   modport sink (input valid, input out_data, input status, input occupancy,
                 output ready);
endinterface

`default_nettype wire

// File: hdl/sorted_priority_queue_core.sv
// Top level of the bounded priority queue built from a chain of sorted slots.
//
// Each request word is an enqueue (data and priority) or a dequeue of the head.
// Entries are kept in descending priority order; equal priorities leave in
// arrival order. Every request word produces exactly one response word with the
// removed data (zero unless a dequeue succeeds), a status and the occupancy.
// An enqueue into a full queue is dropped with status full; a dequeue from an
// empty queue returns status empty.
// The response word appears in the output register on the cycle after the request
// is accepted. Throughput is one word per cycle while the receiver keeps up, since
// every slot compares against the new priority in parallel and shifts by one
// place in the same cycle.
// The request side is ready whenever the output register is empty or is being
// read in the same cycle, so a stalled receiver holds the response word and
// stalls the request side after that one word.
// Synchronous reset empties the queue and the output register; slot contents
// are not cleared, as only occupied slots are ever read.
`default_nettype none

module sorted_priority_queue_core #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  wire     clock,
   input  wire     reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);

   localparam int CountWidth = $clog2(CAPACITY + 1);

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [spq_pkg::DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   spq_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [spq_pkg::OCC_WIDTH-1:0] rsp_occ_ff, rsp_occ_in;

   logic                  fire;
   logic                  is_full;
   logic                  is_empty;
   spq_pkg::cell_cmd_type cmd;
   logic [PRIORITY_BITS-1:0] new_prio;

   logic                                  cell_keep [CAPACITY];
   logic signed [spq_pkg::DATA_WIDTH-1:0] cell_data [CAPACITY];
   logic        [PRIORITY_BITS-1:0]       cell_prio [CAPACITY];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign fire         = req_if.valid && req_if.ready;
   assign is_full      = (count_ff == CountWidth'(CAPACITY));
   assign is_empty     = (count_ff == '0);
   assign new_prio     = PRIORITY_BITS'(req_if.item_priority);

   assign cmd.enq = fire && (req_if.opcode == spq_pkg::OP_ENQUEUE) && !is_full;
   assign cmd.deq = fire && (req_if.opcode == spq_pkg::OP_DEQUEUE) && !is_empty;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                  left_keep;
      logic signed [spq_pkg::DATA_WIDTH-1:0] left_data;
      logic        [PRIORITY_BITS-1:0]       left_prio;
      logic signed [spq_pkg::DATA_WIDTH-1:0] right_data;
      logic        [PRIORITY_BITS-1:0]       right_prio;

      if (i == 0) begin : g_head
         assign left_keep = 1'b1;
         assign left_data = req_if.item_data;
         assign left_prio = new_prio;
      end else begin : g_body
         assign left_keep = cell_keep[i-1];
         assign left_data = cell_data[i-1];
         assign left_prio = cell_prio[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_data = '0;
         assign right_prio = '0;
      end else begin : g_link
         assign right_data = cell_data[i+1];
         assign right_prio = cell_prio[i+1];
      end

      spq_cell #(
         .PRIORITY_BITS(PRIORITY_BITS)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (CountWidth'(i) < count_ff),
         .left_keep (left_keep),
         .new_data  (req_if.item_data),
         .new_prio  (new_prio),
         .left_data (left_data),
         .left_prio (left_prio),
         .right_data(right_data),
         .right_prio(right_prio),
         .keep      (cell_keep[i]),
         .data      (cell_data[i]),
         .prio      (cell_prio[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      rsp_data_in   = '0;
      rsp_status_in = spq_pkg::ST_OK;
      priority if (cmd.enq) begin
         count_in = count_ff + CountWidth'(1);
      end else if (cmd.deq) begin
         count_in    = count_ff - CountWidth'(1);
         rsp_data_in = cell_data[0];
      end else if (req_if.opcode == spq_pkg::OP_ENQUEUE) begin
         rsp_status_in = spq_pkg::ST_FULL;
      end else begin
         rsp_status_in = spq_pkg::ST_EMPTY;
      end
      rsp_occ_in = spq_pkg::OCC_WIDTH'(count_in);
   end

   always_comb begin
      priority if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_data  = rsp_data_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.occupancy = rsp_occ_ff;

endmodule

`default_nettype wire

// File: hdl/spq_cell.sv
// One slot of the sorted queue, exchanging entries with its neighbors.
`default_nettype none

module spq_cell #(
   parameter int PRIORITY_BITS = 8
) (
   input  wire                                    clock,
   input  wire spq_pkg::cell_cmd_type             cmd,
   input  wire                                    occupied,
   input  wire                                    left_keep,
   input  wire signed [spq_pkg::DATA_WIDTH-1:0]   new_data,
   input  wire        [PRIORITY_BITS-1:0]         new_prio,
   input  wire signed [spq_pkg::DATA_WIDTH-1:0]   left_data,
   input  wire        [PRIORITY_BITS-1:0]         left_prio,
   input  wire signed [spq_pkg::DATA_WIDTH-1:0]   right_data,
   input  wire        [PRIORITY_BITS-1:0]         right_prio,
   output logic                                   keep,
   output logic signed [spq_pkg::DATA_WIDTH-1:0]  data,
   output logic        [PRIORITY_BITS-1:0]        prio
);

   logic signed [spq_pkg::DATA_WIDTH-1:0] data_ff, data_in;
   logic        [PRIORITY_BITS-1:0]       prio_ff, prio_in;

   // An occupied slot whose priority is at least the new one stays in place on insert.
   assign keep = occupied && (prio_ff >= new_prio);

   always_comb begin
      data_in = data_ff;
      prio_in = prio_ff;
      priority if (cmd.enq) begin
         if (!keep) begin
            if (left_keep) begin
               data_in = new_data;
               prio_in = new_prio;
            end else begin
               data_in = left_data;
               prio_in = left_prio;
            end
         end
      end else if (cmd.deq) begin
         data_in = right_data;
         prio_in = right_prio;
      end else begin
         data_in = data_ff;
         prio_in = prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      prio_ff <= prio_in;
   end

   assign data = data_ff;
   assign prio = prio_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the sorted priority queue core with random handshake idling.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 8;
   localparam int RANDOM_WORDS  = 900;

   typedef struct {
      logic                                  opcode;
      logic signed [spq_pkg::DATA_WIDTH-1:0] item_data;
      logic [spq_pkg::PRIO_IN_WIDTH-1:0]     item_priority;
   } queue_op_type;

   typedef struct {
      logic signed [spq_pkg::DATA_WIDTH-1:0] out_data;
      spq_pkg::status_type                   status;
      logic [spq_pkg::OCC_WIDTH-1:0]         occupancy;
   } queue_reply_type;

   logic clock;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue_core #(
      .CAPACITY      (CAPACITY),
      .PRIORITY_BITS (PRIORITY_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   queue_op_type    pending_ops[$];
   queue_reply_type awaited_replies[$];

   logic signed [spq_pkg::DATA_WIDTH-1:0] shadow_data [CAPACITY];
   logic [PRIORITY_BITS-1:0]              shadow_prio [CAPACITY];
   int                                    shadow_fill = 0;

   int   failure_count = 0;
   logic op_taken      = 1'b0;
   logic reply_taken   = 1'b0;
   int   send_idle     = 0;
   int   recv_stall    = 0;
   bit   send_calm     = 1'b0;
   bit   recv_calm     = 1'b0;

   always #4 clock = ~clock;

   function automatic queue_reply_type apply_queue_op(queue_op_type op);
      queue_reply_type          reply;
      logic [PRIORITY_BITS-1:0] prio;
      int                       pos;
      reply.out_data = '0;
      reply.status   = spq_pkg::ST_OK;
      prio = op.item_priority[PRIORITY_BITS-1:0];
      if (op.opcode == spq_pkg::OP_ENQUEUE) begin
         if (shadow_fill >= CAPACITY) begin
            reply.status = spq_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_fill && shadow_prio[pos] >= prio) pos++;
            for (int i = shadow_fill; i > pos; i--) begin
               shadow_data[i] = shadow_data[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_data[pos] = op.item_data;
            shadow_prio[pos] = prio;
            shadow_fill++;
         end
      end else begin
         if (shadow_fill == 0) begin
            reply.status = spq_pkg::ST_EMPTY;
         end else begin
            reply.out_data = shadow_data[0];
            for (int i = 1; i < shadow_fill; i++) begin
               shadow_data[i-1] = shadow_data[i];
               shadow_prio[i-1] = shadow_prio[i];
            end
            shadow_fill--;
         end
      end
      reply.occupancy = spq_pkg::OCC_WIDTH'(shadow_fill);
      return reply;
   endfunction

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic note_failure(string what);
      failure_count++;
      if (failure_count <= 10) $display("%0t: %s", $realtime, what);
   endtask

   task automatic queue_word(logic opcode, logic [31:0] data, logic [7:0] prio);
      queue_op_type op;
      op.opcode        = opcode;
      op.item_data     = data;
      op.item_priority = prio;
      pending_ops.push_back(op);
   endtask

   function automatic logic [7:0] draw_priority();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 3) * 85);
   endfunction

   // Sender: holds each word until it is taken, then idles for a drawn number of cycles.
   always @(negedge clock) begin : sender
      queue_op_type op;
      logic         drive_valid;
      drive_valid = req_if.valid;
      if (!reset) begin
         if (req_if.valid && op_taken) begin
            drive_valid = 1'b0;
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_idle = draw_wait(send_calm);
         end
         if (!drive_valid) begin
            if (send_idle > 0) begin
               send_idle--;
            end else if (pending_ops.size() > 0) begin
               op = pending_ops.pop_front();
               req_if.opcode        <= op.opcode;
               req_if.item_data     <= op.item_data;
               req_if.item_priority <= op.item_priority;
               drive_valid = 1'b1;
            end
         end
      end
      req_if.valid <= drive_valid;
   end

   // Receiver: stalls for a drawn number of cycles after each word it takes.
   always @(negedge clock) begin
      if (!reset) begin
         if (reply_taken) begin
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            recv_stall = draw_wait(recv_calm);
         end
         if (recv_stall > 0) begin
            rsp_if.ready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : monitor
      queue_op_type    op;
      queue_reply_type want;
      op_taken    <= !reset && req_if.valid && req_if.ready;
      reply_taken <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_replies.size() == 0) begin
               note_failure($sformatf("unexpected response data=%0d status=%0d occ=%0d",
                                      rsp_if.out_data, rsp_if.status, rsp_if.occupancy));
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_if.out_data !== want.out_data)
                  note_failure($sformatf("out_data expected %0d actual %0d",
                                         want.out_data, rsp_if.out_data));
               if (rsp_if.status !== want.status)
                  note_failure($sformatf("status expected %0d actual %0d",
                                         want.status, rsp_if.status));
               if (rsp_if.occupancy !== want.occupancy)
                  note_failure($sformatf("occupancy expected %0d actual %0d",
                                         want.occupancy, rsp_if.occupancy));
            end
         end
         if (req_if.valid && req_if.ready) begin
            op.opcode        = req_if.opcode;
            op.item_data     = req_if.item_data;
            op.item_priority = req_if.item_priority;
            awaited_replies.push_back(apply_queue_op(op));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int   made;
      int   phase_len;
      int   enq_pct;
      clock                = 1'b0;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.opcode        = spq_pkg::OP_ENQUEUE;
      req_if.item_data     = '0;
      req_if.item_priority = '0;
      rsp_if.ready         = 1'b0;

      // Directed words: empty dequeue, extremes, ties, a full queue and a drop.
      queue_word(spq_pkg::OP_DEQUEUE, 32'h7FFF_FFFF, 8'hFF);
      queue_word(spq_pkg::OP_ENQUEUE, 32'h8000_0000, 8'd0);
      queue_word(spq_pkg::OP_ENQUEUE, 32'h7FFF_FFFF, 8'd255);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd1, 8'd128);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd2, 8'd128);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd3, 8'd128);
      queue_word(spq_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 8'd255);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd0, 8'd0);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd64, 8'd64);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd200, 8'd200);
      queue_word(spq_pkg::OP_ENQUEUE, 32'hAAAA_AAAA, 8'd1);
      queue_word(spq_pkg::OP_ENQUEUE, 32'h5555_5555, 8'd254);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd127, 8'd127);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd129, 8'd129);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd4, 8'd128);
      queue_word(spq_pkg::OP_ENQUEUE, 32'd7, 8'd7);
      queue_word(spq_pkg::OP_ENQUEUE, 32'h1234_5678, 8'd255);
      queue_word(spq_pkg::OP_ENQUEUE, 32'h5A5A_5A5A, 8'd255);
      repeat (4) queue_word(spq_pkg::OP_DEQUEUE, $urandom, draw_priority());

      // Random phases that lean toward filling, draining or holding the queue.
      made = 0;
      while (made < RANDOM_WORDS) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: enq_pct = 20;
            1: enq_pct = 50;
            default: enq_pct = 80;
         endcase
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < enq_pct)
               queue_word(spq_pkg::OP_ENQUEUE, $urandom, draw_priority());
            else
               queue_word(spq_pkg::OP_DEQUEUE, $urandom, draw_priority());
            made++;
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || req_if.valid || awaited_replies.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (failure_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
